### sv/huffman_code_bit_packer_defines.svh
// ----------------------------------------------------------------------------
// Huffman code bit packer assertion macros
// Shared property macros for the packer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HCBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants shared by the prefix-code bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int SYMBOLS      = 256;
    localparam int ADDR_W       = $clog2(SYMBOLS);
    localparam int SYM_W        = 8;
    localparam int MAX_CODE_LEN = 24;
    localparam int CODE_W       = 24;
    localparam int LEN_W        = 5;
    localparam int BYTE_W       = 8;
    localparam int ENTRY_W      = CODE_W + LEN_W;
    // pending byte plus the longest code
    localparam int ACC_W        = BYTE_W + MAX_CODE_LEN;
    localparam int TOT_W        = $clog2(ACC_W + 1);
    localparam int MAX_BYTES    = (BYTE_W - 1 + MAX_CODE_LEN) / BYTE_W;
    localparam int CNT_W        = $clog2(MAX_BYTES + 1);
    localparam int GRP_W        = MAX_BYTES * BYTE_W;
    localparam int PCNT_W       = 3;

    localparam int IN_DATA_W    = ((SYM_W + CODE_W + LEN_W + 7) / 8) * 8;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ENCODE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH  = 2'd2;

    // a group of bytes handed from the packer to the output buffer,
    // earliest byte in the top bits
    typedef struct packed {
        logic               load;
        logic [CNT_W-1:0]   cnt;
        logic [GRP_W-1:0]   bytes;
    } grp_t;

endpackage

### sv/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/hcbp_obuf.sv
// ----------------------------------------------------------------------------
// hcbp_obuf
// Output buffer: holds one group of packed bytes and sends them one word
// at a time, earliest first, with tlast on the final byte of the group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_defines.svh"

module hcbp_obuf
    import hcbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  grp_t              grp,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic              m_tlast
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [GRP_W-1:0] data_reg, data_next;
    logic             take;

    assign take     = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = data_reg[GRP_W-1 -: BYTE_W];
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    // empty now, or empty after this cycle's word goes out
    assign free     = (cnt_reg == '0) || (m_tlast && m_tready);

    always_comb
    begin
        cnt_next  = cnt_reg;
        data_next = data_reg;
        if (grp.load)
        begin
            cnt_next  = grp.cnt;
            data_next = grp.bytes;
        end
        else if (take)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            data_next = data_reg << BYTE_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    `HCBP_ASSERT_NOW(a_load_when_free, grp.load, free, "group loaded over unsent bytes")
    `HCBP_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(MAX_BYTES), "byte count out of range")

endmodule

### sv/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Prefix-code bit packer: loads a code table, packs symbol codes MSB first
// into bytes and flushes the partial byte with zero padding.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_*      in   tuser: func; tdata: symbol, code_bits, code_length
// m_*      out  tdata: out_byte; tlast: last
//
// Two-stage flow: table RAM read at accept, packing in the next cycle.
// One word in per cycle unless the packing stage stalls; an item that fills
// n bytes (n is 0..3) holds the output buffer until they are all sent, which is what sets the sustained rate.
// Reset clears the table's valid bits at once; no clearing pass.
// Output stalls back up through the packing stage to s_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_tuser,    // [1:0] func
    input  logic [IN_DATA_W-1:0] s_tdata,    // [7:0] symbol, [31:8] code_bits,
                                             // [36:32] code_length, rest zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,    // [7:0] out_byte
    output logic                 m_tlast
);

    logic [SYM_W-1:0]  in_sym;
    logic [CODE_W-1:0] in_code;
    logic [LEN_W-1:0]  in_len, sat_len;
    logic              accept, in_range, is_load, is_enc, is_flush;

    logic [SYMBOLS-1:0] vld_reg;
    logic               s1_valid_reg, s1_flush_reg, s1_hit_reg;
    logic               s1_valid_next, s1_go, out_free;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [BYTE_W-1:0] pend_byte_reg, pend_byte_next;
    logic [PCNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    logic [CODE_W-1:0] code_mask, code_val;
    logic [LEN_W-1:0]  code_len;
    logic [TOT_W-1:0]  total, shamt;
    logic [CNT_W-1:0]  nbytes;
    logic [ACC_W-1:0]  acc, acc_sh;
    grp_t              grp;

    assign in_sym   = s_tdata[SYM_W-1:0];
    assign in_code  = s_tdata[SYM_W +: CODE_W];
    assign in_len   = s_tdata[SYM_W + CODE_W +: LEN_W];
    assign accept   = s_tvalid && s_tready;
    assign in_range = ({1'b0, in_sym} < (SYM_W + 1)'(SYMBOLS));
    assign is_load  = (s_tuser == FUNC_LOAD);
    assign is_enc   = (s_tuser == FUNC_ENCODE);
    assign is_flush = (s_tuser == FUNC_FLUSH);
    assign sat_len  = (in_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : in_len;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOLS)
    ) u_table (
        .clk   (clk),
        .we    (accept && is_load && in_range),
        .waddr (in_sym[ADDR_W-1:0]),
        .wdata ({in_code, sat_len}),
        .re    (accept && is_enc),
        .raddr (in_sym[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // ---- packing stage ----
    // an entry never loaded since reset reads as length zero
    assign code_len  = s1_hit_reg ? ram_rdata[LEN_W-1:0] : '0;
    assign code_mask = ~({CODE_W{1'b1}} << code_len);
    assign code_val  = ram_rdata[ENTRY_W-1 -: CODE_W] & code_mask;
    assign total     = TOT_W'(pend_cnt_reg) + TOT_W'(code_len);
    // code's top bit lands just below the pending bits
    assign shamt     = TOT_W'(ACC_W) - total;
    assign acc       = {pend_byte_reg, {(ACC_W-BYTE_W){1'b0}}}
                     | (ACC_W'(code_val) << shamt);
    assign nbytes    = CNT_W'(total >> 3);
    assign acc_sh    = acc << {nbytes, 3'b000};

    always_comb
    begin
        grp.load       = 1'b0;
        grp.cnt        = '0;
        grp.bytes      = acc[ACC_W-1 -: GRP_W];
        pend_byte_next = pend_byte_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (s1_flush_reg)
        begin
            grp.cnt        = CNT_W'(1);
            grp.bytes      = {pend_byte_reg, {(GRP_W-BYTE_W){1'b0}}};
            pend_byte_next = '0;
            pend_cnt_next  = '0;
        end
        else
        begin
            grp.cnt        = nbytes;
            pend_byte_next = acc_sh[ACC_W-1 -: BYTE_W];
            pend_cnt_next  = total[PCNT_W-1:0];
        end
        grp.load = s1_go && (grp.cnt != '0);
    end

    // an encode that fills no byte moves on without the output buffer
    assign s1_go    = s1_valid_reg && ((!s1_flush_reg && (nbytes == '0)) || out_free);
    assign s_tready = !s1_valid_reg || s1_go;

    // loads and words with an undefined func finish at accept
    assign s1_valid_next = accept ? (is_flush || (is_enc && in_range))
                                  : (s1_valid_reg && !s1_go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            pend_byte_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept && is_load && in_range)
            begin
                vld_reg[in_sym[ADDR_W-1:0]] <= 1'b1;
            end
            if (s1_go)
            begin
                pend_byte_reg <= pend_byte_next;
                pend_cnt_reg  <= pend_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flush_reg <= is_flush;
            s1_hit_reg   <= vld_reg[in_sym[ADDR_W-1:0]];
        end
    end

    hcbp_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .grp      (grp),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `HCBP_ASSERT_NEXT(a_flush_clears, s1_go && s1_flush_reg, pend_cnt_reg == '0, "flush left bits pending")
    `HCBP_ASSERT_NOW(a_unused_silent, s1_valid_reg && !s1_flush_reg && !s1_hit_reg, grp.cnt == '0, "unused symbol produced bytes")
    `HCBP_ASSERT_NOW(a_accept_moves, accept, !s1_valid_reg || s1_go, "item accepted over a stalled stage")

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the prefix-code bit packer. A directed table of
// loads, encodes, flushes and one undefined func, then random words over
// three flow-control phases. Each accepted word runs through an in-bench
// packing model; output bytes are checked in order against the model or fixed row bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import hcbp_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;    // undefined func, must be ignored
    localparam logic [2:0] USE_MODEL = 3'd7;    // row result comes from the model
    localparam int         DIR_N     = 25;
    localparam int         PHASE_N   = 68;
    localparam int         HOLD_CYC  = 300;
    localparam int         LIMIT     = 200000;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  sym;
        logic [23:0] code;
        logic [4:0]  len;
    } word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } obyte_t;

    // n_fixed bytes typed in, earliest byte highest; USE_MODEL defers to the model
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  sym;
        logic [23:0] code;
        logic [4:0]  len;
        logic [2:0]  n_fixed;
        logic [23:0] fixed;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [1:0]           s_tuser = '0;     // [1:0] func
    logic [IN_DATA_W-1:0] s_tdata = '0;     // [7:0] symbol, [31:8] code_bits,
                                            // [36:32] code_length, rest zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;          // [7:0] out_byte
    logic                 m_tlast;

    // packing model state
    logic [23:0] code_tab [256];
    logic [4:0]  len_tab  [256];
    logic [7:0]  acc_byte = '0;
    int          acc_cnt = 0;

    obyte_t      fresh_q[$];     // bytes produced by the word just accepted
    obyte_t      packed_q[$];    // bytes still to come out of the block

    int          err_cnt = 0;
    int          cycle_cnt = 0;
    int          tx_idle_pct = 38;
    int          rx_idle_pct = 72;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;

    row_t dir_tab [DIR_N] = '{
        '{FUNC_FLUSH,  8'd0,   24'h000000, 5'd0,  3'd1,      24'h000000},
        '{FUNC_ENCODE, 8'd0,   24'h000000, 5'd0,  3'd0,      24'h000000},
        '{FUNC_LOAD,   8'd0,   24'hFFFFFF, 5'd24, 3'd0,      24'h000000},
        '{FUNC_ENCODE, 8'd0,   24'h000000, 5'd0,  3'd3,      24'hFFFFFF},
        '{FUNC_LOAD,   8'd255, 24'h000001, 5'd31, 3'd0,      24'h000000},
        '{FUNC_ENCODE, 8'd255, 24'h000000, 5'd0,  3'd3,      24'h000001},
        '{FUNC_LOAD,   8'd1,   24'h000005, 5'd3,  3'd0,      24'h000000},
        '{FUNC_ENCODE, 8'd1,   24'h000000, 5'd0,  USE_MODEL, 24'h000000},
        '{FUNC_ENCODE, 8'd0,   24'h000000, 5'd0,  USE_MODEL, 24'h000000},
        '{FUNC_FLUSH,  8'd0,   24'h000000, 5'd0,  USE_MODEL, 24'h000000},
        '{FUNC_FLUSH,  8'd0,   24'h000000, 5'd0,  3'd1,      24'h000000},
        '{FUNC_LOAD,   8'd2,   24'hABCDEF, 5'd0,  3'd0,      24'h000000},
        '{FUNC_ENCODE, 8'd2,   24'h000000, 5'd0,  3'd0,      24'h000000},
        '{FUNC_NONE,   8'd7,   24'hFFFFFF, 5'd31, 3'd0,      24'h000000},
        '{FUNC_ENCODE, 8'd7,   24'h000000, 5'd0,  3'd0,      24'h000000},
        '{FUNC_LOAD,   8'd128, 24'hFFFF00, 5'd8,  3'd0,      24'h000000},
        '{FUNC_ENCODE, 8'd128, 24'h000000, 5'd0,  3'd1,      24'h000000},
        '{FUNC_LOAD,   8'd3,   24'h00007F, 5'd7,  3'd0,      24'h000000},
        '{FUNC_ENCODE, 8'd3,   24'h000000, 5'd0,  USE_MODEL, 24'h000000},
        '{FUNC_ENCODE, 8'd128, 24'h000000, 5'd0,  USE_MODEL, 24'h000000},
        '{FUNC_ENCODE, 8'd0,   24'h000000, 5'd0,  USE_MODEL, 24'h000000},
        '{FUNC_FLUSH,  8'd0,   24'h000000, 5'd0,  USE_MODEL, 24'h000000},
        '{FUNC_LOAD,   8'd170, 24'h555555, 5'd16, 3'd0,      24'h000000},
        '{FUNC_ENCODE, 8'd170, 24'h000000, 5'd0,  3'd2,      24'h005555},
        '{FUNC_LOAD,   8'd85,  24'hAAAAAA, 5'd25, 3'd0,      24'h000000}
    };

    huffman_code_bit_packer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            code_tab[i] = '0;
            len_tab[i]  = '0;
        end
    end

    // applies one word to the model; bytes it completes land in fresh_q
    function automatic void pack_symbol(input word_t w);
        logic [23:0] c;
        obyte_t      ob;
        logic        have;
        fresh_q.delete();
        have = 1'b0;
        ob   = '0;
        case (w.func)
            FUNC_LOAD:
            begin
                code_tab[w.sym] = w.code;
                len_tab[w.sym]  = (w.len > MAX_CODE_LEN) ? 5'(MAX_CODE_LEN) : w.len;
            end
            FUNC_ENCODE:
            begin
                c = code_tab[w.sym];
                for (int i = int'(len_tab[w.sym]) - 1; i >= 0; i--)
                begin
                    acc_byte[3'(7 - acc_cnt)] = c[i];
                    acc_cnt++;
                    if (acc_cnt == 8)
                    begin
                        // hold the newest byte back so the final one can carry last
                        if (have)
                            fresh_q.push_back(ob);
                        ob       = '{data: acc_byte, last: 1'b0};
                        have     = 1'b1;
                        acc_byte = '0;
                        acc_cnt  = 0;
                    end
                end
                if (have)
                begin
                    ob.last = 1'b1;
                    fresh_q.push_back(ob);
                end
            end
            FUNC_FLUSH:
            begin
                fresh_q.push_back('{data: acc_byte, last: 1'b1});
                acc_byte = '0;
                acc_cnt  = 0;
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(input word_t w, input logic [2:0] n_fixed,
                             input logic [23:0] fixed);
        obyte_t ob;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.func;
        s_tdata  <= {3'b000, w.len, w.code, w.sym};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pack_symbol(w);
        if (n_fixed == USE_MODEL)
        begin
            foreach (fresh_q[i])
                packed_q.push_back(fresh_q[i]);
        end
        else
        begin
            for (int i = 0; i < int'(n_fixed); i++)
            begin
                ob.data = fixed[8 * (int'(n_fixed) - 1 - i) +: 8];
                ob.last = (i == int'(n_fixed) - 1);
                packed_q.push_back(ob);
            end
        end
    endtask

    // output side: random back-pressure plus one long hold in the last phase
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYC;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        obyte_t ob;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (packed_q.size() == 0)
            begin
                $error("out_byte %02h (last %0d) with no word pending", m_tdata, m_tlast);
                err_cnt++;
            end
            else
            begin
                ob = packed_q.pop_front();
                if (m_tdata !== ob.data)
                begin
                    $error("out_byte mismatch: expected %02h, actual %02h", ob.data, m_tdata);
                    err_cnt++;
                end
                if (m_tlast !== ob.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", ob.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        word_t w;
        int    r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
        begin
            w = '{func: dir_tab[k].func, sym: dir_tab[k].sym,
                  code: dir_tab[k].code, len: dir_tab[k].len};
            send_word(w, dir_tab[k].n_fixed, dir_tab[k].fixed);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                tx_idle_pct = 72;
                rx_idle_pct <= 38;
            end
            else if (ph == 2)
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                hold_go     <= 1'b1;
            end
            for (int k = 0; k < PHASE_N; k++)
            begin
                w.code = 24'($urandom);
                w.len  = 5'($urandom);
                // most traffic on a few symbols so encodes hit loaded entries
                w.sym  = ($urandom_range(99) < 75) ? 8'($urandom_range(15) * 17)
                                                   : 8'($urandom);
                r = $urandom_range(99);
                if (r < 35)
                begin
                    w.func = FUNC_LOAD;
                    r = $urandom_range(99);
                    if (r < 85)
                        w.len = 5'($urandom_range(1, MAX_CODE_LEN));
                    else if (r < 93)
                        w.len = 5'd0;
                    else
                        w.len = 5'($urandom_range(MAX_CODE_LEN + 1, 31));
                end
                else if (r < 88)
                    w.func = FUNC_ENCODE;
                else if (r < 97)
                    w.func = FUNC_FLUSH;
                else
                    w.func = FUNC_NONE;
                send_word(w, USE_MODEL, 24'h000000);
            end
        end
        s_tvalid <= 1'b0;

        while (packed_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
